// ===== sv/mips_subset_execute_unit_top_defines.svh =====
// Assertion macros shared by the execute unit RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MIPS_SUBSET_EXECUTE_UNIT_TOP_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define MSEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled while in reset
`define MSEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSEU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MSEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/mseu_pkg.sv =====
// Shared types and constants of the MIPS subset execute unit.
// No dependencies; used by controller, datapath and top level.
package mseu_pkg;

    // item operation codes
    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_JR_MIS = 3'd1;
    localparam logic [2:0] ST_UNDEF  = 3'd2;
    localparam logic [2:0] ST_FAULT  = 3'd3;
    localparam logic [2:0] ST_HALT   = 3'd4;

    // primary opcodes
    localparam logic [5:0] OPC_RTYPE = 6'h00;
    localparam logic [5:0] OPC_J     = 6'h02;
    localparam logic [5:0] OPC_JAL   = 6'h03;
    localparam logic [5:0] OPC_BEQ   = 6'h04;
    localparam logic [5:0] OPC_BNE   = 6'h05;
    localparam logic [5:0] OPC_BLEZ  = 6'h06;
    localparam logic [5:0] OPC_BGTZ  = 6'h07;
    localparam logic [5:0] OPC_ADDI  = 6'h08;
    localparam logic [5:0] OPC_LUI   = 6'h0F;
    localparam logic [5:0] OPC_LW    = 6'h23;
    localparam logic [5:0] OPC_SW    = 6'h2B;

    // R-type function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // register indexes
    localparam logic [4:0] REG_SP = 5'd29;
    localparam logic [4:0] REG_RA = 5'd31;

    // reset values of the configuration registers
    localparam logic [31:0] TEXT_LIMIT_RST = 32'd4096;
    localparam logic [31:0] STACK_TOP_RST  = 32'd65532;

    // configuration register indexes
    localparam logic CFG_TEXT_LIMIT = 1'b0;
    localparam logic CFG_STACK_TOP  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic ld_item;
        logic commit;
        logic div_start;
        logic fin_commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_div;
        logic div_done;
        logic out_free;
    } t_sts;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] next_pc;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        reg_write_en;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        awaiting_load;
    } t_res;

endpackage

// ===== sv/mips_subset_execute_unit_top.sv =====
// MIPS subset execute unit: top level with the configuration registers.
// Uses mseu_pkg, mseu_ctrl and mseu_dp.
//
// Usage: each input item on s_axis carries an operation in tuser (init,
// execute fetched instruction, load return) and the instruction word, load
// word and fault flag in tdata. Every item gives exactly one result item on
// m_axis: status in tuser, next fetch address, data memory request and
// general register write in tdata. A load is two items: execute issues the
// read and sets awaiting_load, the load return item writes the register.
// The input is latched in the accept state and executed in the execute
// state, which loads the result into the output register once it is free;
// a new item is taken only after the controller is back in idle. DIV runs
// through a one-bit-per-cycle divider: the item waits in the divide state
// until it is done, then the finish state writes HI/LO and the result.
// When m_axis stalls, one result waits in the output register, the next
// item is still taken and holds in the execute step until the slot frees.
// Reset clears pc, HI/LO, the load and stop flags and marks the register
// file unwritten (register 29 reads as the stack top reset value); the
// APB registers text_limit (0x0) and stack_top (0x4) return to defaults.
module mips_subset_execute_unit_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // stream in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // instr_word[31:0], load_data[63:32], mem_fault[64]
    input  logic [1:0]   s_axis_tuser,   // operation[1:0]
    // stream out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[31:0], mem_read[32], mem_write[33], mem_addr[65:34], mem_wdata[97:66],
    // reg_write_en[98], reg_write_index[103:99], reg_write_value[135:104],
    // awaiting_load[136]
    output logic [143:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // status[2:0]
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [31:0]    r_text_limit;
    logic [31:0]    r_stack_top;
    mseu_pkg::t_cmd cmd;
    mseu_pkg::t_sts sts;
    mseu_pkg::t_res res;

    // APB registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_limit <= mseu_pkg::TEXT_LIMIT_RST;
            r_stack_top  <= mseu_pkg::STACK_TOP_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == mseu_pkg::CFG_STACK_TOP) begin
                r_stack_top <= pwdata;
            end else begin
                r_text_limit <= pwdata;
            end
        end
    end

    assign prdata = (paddr[2] == mseu_pkg::CFG_STACK_TOP) ? r_stack_top : r_text_limit;

    mseu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mseu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (s_axis_tuser),
        .i_ins        (s_axis_tdata[31:0]),
        .i_ld         (s_axis_tdata[63:32]),
        .i_fault      (s_axis_tdata[64]),
        .i_text_limit (r_text_limit),
        .i_stack_top  (r_stack_top),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_res        (res)
    );

    // pack the result item
    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.awaiting_load, res.reg_write_value, res.reg_write_index,
                           res.reg_write_en, res.mem_wdata, res.mem_addr, res.mem_write,
                           res.mem_read, res.next_pc};

endmodule

// ===== sv/mseu_ctrl.sv =====
// Sequencer of the execute unit: accept, execute, divide wait, finish.
// Uses mseu_pkg command and status structs.
`include "mips_subset_execute_unit_top_defines.svh"
module mseu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mseu_pkg::t_sts  i_sts,
    output mseu_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DIVW = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIVW;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MSEU_ASSERT_IMPL(a_commit_free, i_clk, i_rst_n, o_cmd.commit || o_cmd.fin_commit, i_sts.out_free, "result loaded while output busy")
    `MSEU_ASSERT_NEXT(a_div_fin, i_clk, i_rst_n, r_state == S_DIVW && i_sts.div_done, r_state == S_FIN, "divide done not followed by finish")
    `MSEU_ASSERT_IMPL(a_start_exec, i_clk, i_rst_n, o_cmd.div_start, r_state == S_EXEC, "divide started outside execute")

endmodule

// ===== sv/mseu_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Self-contained; divide by zero gives zero quotient and remainder.
module mseu_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_q;
    logic [31:0] r_r;
    logic [31:0] r_mb;
    logic        r_neg_q;
    logic        r_neg_r;
    logic        r_zero;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] trial;
    logic [32:0] diff;

    assign mag_a = i_a[31] ? (32'd0 - i_a) : i_a;
    assign mag_b = i_b[31] ? (32'd0 - i_b) : i_b;
    assign trial = {r_r, r_q[31]};
    assign diff  = trial - {1'b0, r_mb};

    // restoring step: shift in next dividend bit, subtract if it fits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_q     <= mag_a;
                r_r     <= '0;
                r_mb    <= mag_b;
                r_neg_q <= i_a[31] ^ i_b[31];
                r_neg_r <= i_a[31];
                r_zero  <= (i_b == 32'd0);
            end else if (r_busy) begin
                if (!diff[32]) begin
                    r_r <= diff[31:0];
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_r <= trial[31:0];
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? 32'd0 : (r_neg_q ? (32'd0 - r_q) : r_q);
    assign o_rem  = r_zero ? 32'd0 : (r_neg_r ? (32'd0 - r_r) : r_r);

endmodule

// ===== sv/mseu_dp.sv =====
// Datapath: item latch, register file, HI/LO, pc, decode/execute, output register.
// Uses mseu_pkg and instantiates mseu_div.
`include "mips_subset_execute_unit_top_defines.svh"
module mseu_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mseu_pkg::t_cmd    i_cmd,
    output mseu_pkg::t_sts    o_sts,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_ins,
    input  logic [31:0]       i_ld,
    input  logic              i_fault,
    input  logic [31:0]       i_text_limit,
    input  logic [31:0]       i_stack_top,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mseu_pkg::t_res    o_res
);

    // latched item
    logic [1:0]  r_op;
    logic [31:0] r_ins;
    logic [31:0] r_ld;
    logic        r_fault;

    // architectural state
    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_pc;
    logic [31:0] r_hi;
    logic [31:0] r_lo;
    logic [4:0]  r_pend;
    logic        r_lp;
    logic        r_stop;

    // registered reads
    logic [31:0] r_rdat_a;
    logic [31:0] r_rdat_b;
    logic        r_va;
    logic        r_vb;
    logic        r_sp_a;
    logic        r_sp_b;

    logic        r_ov;
    mseu_pkg::t_res r_res;

    logic [31:0] a_val;
    logic [31:0] b_val;
    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  sa;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] im;
    logic [31:0] tgt;
    logic [63:0] rot;
    logic [63:0] prod;
    logic        halted;
    logic        take;

    logic [2:0]  st;
    logic [31:0] n_pc;
    logic        n_lp;
    logic [4:0]  n_pend;
    logic        stop_set;
    logic        do_mult;
    logic        do_div;
    logic        do_init;
    logic        req_we;
    logic [4:0]  req_idx;
    logic [31:0] req_val;
    logic        we;
    logic        mr;
    logic        mw;
    logic [31:0] maddr;
    logic [31:0] mwd;
    mseu_pkg::t_res c_res;
    mseu_pkg::t_res f_res;

    logic        div_done;
    logic [31:0] div_q;
    logic [31:0] div_r;
    logic        out_free;

    // latch item and read both source registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_op     <= i_op;
            r_ins    <= i_ins;
            r_ld     <= i_ld;
            r_fault  <= i_fault;
            r_rdat_a <= r_mem[i_ins[25:21]];
            r_rdat_b <= r_mem[i_ins[20:16]];
            r_va     <= r_vld[i_ins[25:21]];
            r_vb     <= r_vld[i_ins[20:16]];
            r_sp_a   <= (i_ins[25:21] == mseu_pkg::REG_SP);
            r_sp_b   <= (i_ins[20:16] == mseu_pkg::REG_SP);
        end
    end

    // entries never written read as their reset value
    assign a_val = r_va ? r_rdat_a : (r_sp_a ? mseu_pkg::STACK_TOP_RST : 32'd0);
    assign b_val = r_vb ? r_rdat_b : (r_sp_b ? mseu_pkg::STACK_TOP_RST : 32'd0);

    assign opc  = r_ins[31:26];
    assign fn   = r_ins[5:0];
    assign sa   = r_ins[10:6];
    assign rd   = r_ins[15:11];
    assign rt   = r_ins[20:16];
    assign rs   = r_ins[25:21];
    assign im   = {{16{r_ins[15]}}, r_ins[15:0]};
    assign tgt  = {r_pc[31:28], r_ins[25:0], 2'b00};
    assign rot  = {b_val, b_val} >> sa;
    assign prod = $signed({{32{a_val[31]}}, a_val}) * $signed({{32{b_val[31]}}, b_val});
    assign halted = r_stop || (r_pc >= i_text_limit);

    // decode and execute
    always_comb begin
        st       = mseu_pkg::ST_OK;
        n_pc     = r_pc;
        n_lp     = r_lp;
        n_pend   = r_pend;
        stop_set = 1'b0;
        do_mult  = 1'b0;
        do_div   = 1'b0;
        do_init  = 1'b0;
        req_we   = 1'b0;
        req_idx  = '0;
        req_val  = '0;
        mr       = 1'b0;
        mw       = 1'b0;
        maddr    = '0;
        mwd      = '0;
        take     = 1'b0;
        if (r_op == mseu_pkg::OP_INIT) begin
            do_init = 1'b1;
            n_pc    = '0;
            n_lp    = 1'b0;
            n_pend  = '0;
        end else if (r_op == mseu_pkg::OP_EXEC && !halted && !r_lp) begin
            if (r_fault) begin
                st = mseu_pkg::ST_FAULT;
            end else if (opc == mseu_pkg::OPC_RTYPE) begin
                n_pc    = r_pc + 32'd4;
                req_idx = rd;
                case (fn)
                    mseu_pkg::FN_ADD: begin
                        req_we = 1'b1; req_val = a_val + b_val;
                    end
                    mseu_pkg::FN_AND: begin
                        req_we = 1'b1; req_val = a_val & b_val;
                    end
                    mseu_pkg::FN_OR: begin
                        req_we = 1'b1; req_val = a_val | b_val;
                    end
                    mseu_pkg::FN_XOR: begin
                        req_we = 1'b1; req_val = a_val ^ b_val;
                    end
                    mseu_pkg::FN_SUB: begin
                        req_we = 1'b1; req_val = a_val - b_val;
                    end
                    mseu_pkg::FN_SLT: begin
                        req_we  = 1'b1;
                        req_val = {31'd0, $signed(a_val) < $signed(b_val)};
                    end
                    mseu_pkg::FN_SLL: begin
                        req_we = 1'b1; req_val = b_val << sa;
                    end
                    mseu_pkg::FN_SRL: begin
                        // rs bit 0 selects rotate
                        req_we  = 1'b1;
                        req_val = rs[0] ? rot[31:0] : (b_val >> sa);
                    end
                    mseu_pkg::FN_MFHI: begin
                        req_we = 1'b1; req_val = r_hi;
                    end
                    mseu_pkg::FN_MFLO: begin
                        req_we = 1'b1; req_val = r_lo;
                    end
                    mseu_pkg::FN_MULT:    do_mult = 1'b1;
                    mseu_pkg::FN_DIV:     do_div  = 1'b1;
                    mseu_pkg::FN_SYSCALL: ;
                    mseu_pkg::FN_JR: begin
                        if (a_val[1:0] != 2'b00) begin
                            st = mseu_pkg::ST_JR_MIS;
                        end else begin
                            n_pc = a_val;
                        end
                    end
                    default: st = mseu_pkg::ST_UNDEF;
                endcase
            end else begin
                n_pc    = r_pc + 32'd4;
                req_idx = rt;
                case (opc)
                    mseu_pkg::OPC_ADDI: begin
                        req_we = 1'b1; req_val = a_val + im;
                    end
                    mseu_pkg::OPC_LUI: begin
                        req_we = 1'b1; req_val = {r_ins[15:0], 16'd0};
                    end
                    mseu_pkg::OPC_BEQ, mseu_pkg::OPC_BNE,
                    mseu_pkg::OPC_BGTZ, mseu_pkg::OPC_BLEZ: begin
                        case (opc)
                            mseu_pkg::OPC_BEQ:  take = (a_val == b_val);
                            mseu_pkg::OPC_BNE:  take = (a_val != b_val);
                            mseu_pkg::OPC_BGTZ: take = !a_val[31] && (a_val != 32'd0);
                            default:            take = a_val[31] || (a_val == 32'd0);
                        endcase
                        n_pc = r_pc + (take ? {im[29:0], 2'b00} : 32'd4);
                    end
                    mseu_pkg::OPC_LW: begin
                        // pc advances when the load returns
                        mr     = 1'b1;
                        maddr  = a_val + im;
                        n_pend = rt;
                        n_lp   = 1'b1;
                        n_pc   = r_pc;
                    end
                    mseu_pkg::OPC_SW: begin
                        mw    = 1'b1;
                        maddr = a_val + im;
                        mwd   = b_val;
                    end
                    mseu_pkg::OPC_J: n_pc = tgt;
                    mseu_pkg::OPC_JAL: begin
                        req_we  = 1'b1;
                        req_idx = mseu_pkg::REG_RA;
                        req_val = r_pc + 32'd4;
                        n_pc    = tgt;
                    end
                    default: st = mseu_pkg::ST_UNDEF;
                endcase
            end
            // error stop: nothing changes but the stop flag
            if (st != mseu_pkg::ST_OK) begin
                stop_set = 1'b1;
                n_pc     = r_pc;
                n_lp     = r_lp;
                n_pend   = r_pend;
                do_mult  = 1'b0;
                do_div   = 1'b0;
                req_we   = 1'b0;
                mr       = 1'b0;
                mw       = 1'b0;
                maddr    = '0;
                mwd      = '0;
            end
        end else if (r_op == mseu_pkg::OP_LOAD && r_lp) begin
            n_lp = 1'b0;
            if (r_fault) begin
                st       = mseu_pkg::ST_FAULT;
                stop_set = 1'b1;
            end else begin
                req_we  = 1'b1;
                req_idx = r_pend;
                req_val = r_ld;
                n_pc    = r_pc + 32'd4;
            end
        end else begin
            st = halted ? mseu_pkg::ST_HALT : mseu_pkg::ST_OK;
        end
    end

    // register 0 writes are dropped
    assign we = req_we && (req_idx != 5'd0);

    always_comb begin
        c_res                 = '0;
        c_res.status          = st;
        c_res.next_pc         = n_pc;
        c_res.mem_read        = mr;
        c_res.mem_write       = mw;
        c_res.mem_addr        = maddr;
        c_res.mem_wdata       = mwd;
        c_res.reg_write_en    = we;
        c_res.reg_write_index = we ? req_idx : 5'd0;
        c_res.reg_write_value = we ? req_val : 32'd0;
        c_res.awaiting_load   = n_lp;
        f_res                 = '0;
        f_res.status          = mseu_pkg::ST_OK;
        f_res.next_pc         = r_pc + 32'd4;
        f_res.awaiting_load   = r_lp;
    end

    // register file write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (we || do_init)) begin
            r_mem[do_init ? mseu_pkg::REG_SP : req_idx] <= do_init ? i_stack_top : req_val;
        end
    end

    // architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pc   <= '0;
            r_hi   <= '0;
            r_lo   <= '0;
            r_pend <= '0;
            r_lp   <= 1'b0;
            r_stop <= 1'b0;
        end else if (i_cmd.commit) begin
            if (do_init) begin
                r_vld  <= 32'd1 << mseu_pkg::REG_SP;
                r_pc   <= '0;
                r_hi   <= '0;
                r_lo   <= '0;
                r_pend <= '0;
                r_lp   <= 1'b0;
                r_stop <= 1'b0;
            end else begin
                r_pc   <= n_pc;
                r_lp   <= n_lp;
                r_pend <= n_pend;
                if (stop_set) begin
                    r_stop <= 1'b1;
                end
                if (do_mult) begin
                    r_hi <= prod[63:32];
                    r_lo <= prod[31:0];
                end
                if (we) begin
                    r_vld[req_idx] <= 1'b1;
                end
            end
        end else if (i_cmd.fin_commit) begin
            r_pc <= r_pc + 32'd4;
            r_hi <= div_r;
            r_lo <= div_q;
        end
    end

    mseu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_a     (a_val),
        .i_b     (b_val),
        .o_done  (div_done),
        .o_quot  (div_q),
        .o_rem   (div_r)
    );

    // output register
    assign out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.commit || i_cmd.fin_commit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= c_res;
        end else if (i_cmd.fin_commit) begin
            r_res <= f_res;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_res          = r_res;
    assign o_sts.is_div   = do_div;
    assign o_sts.div_done = div_done;
    assign o_sts.out_free = out_free;

    `MSEU_ASSERT_IMPL(a_r0_invalid, i_clk, i_rst_n, 1'b1, !r_vld[0], "register 0 marked written")
    `MSEU_ASSERT_NEXT(a_init_clear, i_clk, i_rst_n, i_cmd.commit && do_init, r_pc == 32'd0 && !r_lp && !r_stop, "init left state behind")
    `MSEU_ASSERT_IMPL(a_no_mult_on_err, i_clk, i_rst_n, stop_set, !we && !do_mult && !do_div, "state written on error stop")

endmodule
